/* rtl/core/tridiagonal_solver_defines.svh */
// Assertion macros for the tridiagonal solver.
`ifndef TRIDIAGONAL_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_SOLVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TDS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDS_ASSERT(label, clk, rst_n, prop, msg)
`define TDS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/core/tds_pkg.sv */
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and constants of the tridiagonal solver.
// ----------------------------------------------------------------------------
package tds_pkg;
    localparam int MAX_N_DEF     = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int W             = 32;
    localparam int IDX_W         = 6;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_MUL, S_SUM, S_DIVA, S_WAITA, S_DIVB, S_WAITB, S_WR,
        S_BRD, S_BMUL, S_BOUT
    } t_state;

    function automatic logic signed [W-1:0] sat(input logic signed [65:0] v);
        logic signed [W-1:0] r;
        if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000) r = 32'sh8000_0000;
        else r = v[W-1:0];
        return r;
    endfunction
endpackage

/* rtl/core/tds_div.sv */
// ----------------------------------------------------------------------------
// tds_div
// Restoring divider, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module tds_div #(
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [tds_pkg::W:0]     i_num,
    input  logic signed [tds_pkg::W-1:0]   i_den,
    output logic                           o_done,
    output logic signed [tds_pkg::W-1:0]   o_quo
);
    localparam int NW = tds_pkg::W + 1 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [tds_pkg::W:0] r_rem;
    logic [tds_pkg::W-1:0] r_d;
    logic r_neg;
    logic [CW-1:0] r_cnt;
    logic r_busy;
    logic r_done;
    logic [tds_pkg::W+1:0] trial;
    logic [NW-1:0] an;
    logic signed [65:0] qs;

    assign an = i_num[tds_pkg::W] ? NW'(-(NW'(i_num)) << FRAC_BITS)
                                  : NW'(NW'(i_num) << FRAC_BITS);
    assign trial = {r_rem, r_q[NW-1]} - {2'b00, r_d};
    assign qs = r_neg ? -66'(r_q) : 66'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= an;
            r_rem <= '0;
            r_d   <= i_den[tds_pkg::W-1] ? -i_den : i_den;
            r_neg <= i_num[tds_pkg::W] ^ i_den[tds_pkg::W-1];
        end else if (r_busy) begin
            if (!trial[tds_pkg::W+1]) begin
                r_rem <= trial[tds_pkg::W:0];
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[tds_pkg::W-1:0], r_q[NW-1]};
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = tds_pkg::sat(qs);
endmodule

/* rtl/core/tridiagonal_solver.sv */
// ----------------------------------------------------------------------------
// tridiagonal_solver
// Thomas-algorithm solver: forward sweep into coefficient memories, then
// back substitution on the last row.
// ----------------------------------------------------------------------------
// Usage: rows enter on the input channel (i_valid/o_stall), one row per
// transfer, the last one flagged by i_last_row. Results leave on the output
// channel (o_valid/i_stall) only after the last row, from the highest row
// index down to zero; o_final_entry marks index zero.
// After its transfer a row occupies the block while the bit-serial divider
// runs twice (alpha then beta); the next row can transfer once the block is
// idle again. A row with a zero denominator skips the divider, and a row
// beyond MAX_N skips the whole sweep.
// Back substitution produces each result by memory read, multiply, and sum
// into the output register; a stalled output register holds the machine.
// Reset (synchronous, active low) clears the row count and error flag;
// the alpha and beta memories need no clearing.
// o_stall is high while a row or back substitution is in progress.
// ----------------------------------------------------------------------------
`include "tridiagonal_solver_defines.svh"
module tridiagonal_solver #(
    parameter int MAX_N     = tds_pkg::MAX_N_DEF,
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [tds_pkg::W-1:0]        i_sub_coef,
    input  logic signed [tds_pkg::W-1:0]        i_diag_coef,
    input  logic signed [tds_pkg::W-1:0]        i_super_coef,
    input  logic signed [tds_pkg::W-1:0]        i_rhs_value,
    input  logic                                i_last_row,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tds_pkg::W-1:0]        o_solution_value,
    output logic [tds_pkg::IDX_W-1:0]           o_solution_index,
    output logic                                o_final_entry,
    output logic                                o_solve_error
);
    localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW = $clog2(MAX_N + 1);
    localparam int W  = tds_pkg::W;

    tds_pkg::t_state r_state, n_state;
    logic signed [W-1:0] r_alpha_mem [MAX_N];
    logic signed [W-1:0] r_beta_mem  [MAX_N];
    logic signed [W-1:0] r_ra, r_rb;
    logic signed [W-1:0] r_a, r_b, r_c, r_d;
    logic r_last;
    logic [CW-1:0] r_count;
    logic r_err;
    logic signed [63:0] r_p1, r_p2;
    logic signed [W-1:0] r_den, r_num;
    logic signed [W-1:0] r_alpha, r_beta;
    logic signed [W-1:0] r_x;
    logic [AW-1:0] r_k;
    logic r_first_back;
    logic r_ov;
    logic signed [W-1:0] r_ov_val;
    logic [tds_pkg::IDX_W-1:0] r_ov_idx;
    logic r_ov_fin, r_ov_err;
    logic [AW-1:0] idx;
    logic div_start, div_done;
    logic signed [W:0] div_num;
    logic signed [W-1:0] div_quo;
    logic accept;
    logic zero_den;
    logic [AW-1:0] rd_addr;
    logic signed [W-1:0] pm1, pm2;

    function automatic logic signed [W-1:0] qscale(input logic signed [63:0] p);
        logic signed [65:0] s;
        s = 66'(p) >>> FRAC_BITS;
        return tds_pkg::sat(s);
    endfunction

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != tds_pkg::S_IDLE);
    assign idx      = r_count[AW-1:0];
    assign zero_den = (r_den == '0);
    assign rd_addr  = (r_state == tds_pkg::S_RD) ? AW'(r_count - 1'b1) : r_k;
    assign pm1      = qscale(r_p1);
    assign pm2      = qscale(r_p2);

    tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tds_pkg::S_IDLE: if (accept) n_state = tds_pkg::S_RD;
            tds_pkg::S_RD: begin
                if (r_count >= CW'(MAX_N)) begin
                    n_state = r_last ? tds_pkg::S_BRD : tds_pkg::S_IDLE;
                end else begin
                    n_state = tds_pkg::S_MUL;
                end
            end
            tds_pkg::S_MUL:   n_state = tds_pkg::S_SUM;
            tds_pkg::S_SUM:   n_state = tds_pkg::S_DIVA;
            tds_pkg::S_DIVA:  n_state = zero_den ? tds_pkg::S_WR : tds_pkg::S_WAITA;
            tds_pkg::S_WAITA: if (div_done) n_state = tds_pkg::S_DIVB;
            tds_pkg::S_DIVB:  n_state = tds_pkg::S_WAITB;
            tds_pkg::S_WAITB: if (div_done) n_state = tds_pkg::S_WR;
            tds_pkg::S_WR:    n_state = r_last ? tds_pkg::S_BRD : tds_pkg::S_IDLE;
            tds_pkg::S_BRD:   if (!r_ov || !i_stall) n_state = tds_pkg::S_BMUL;
            tds_pkg::S_BMUL:  n_state = tds_pkg::S_BOUT;
            tds_pkg::S_BOUT:  n_state = (r_k == '0) ? tds_pkg::S_IDLE : tds_pkg::S_BRD;
            default:          n_state = tds_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = -(W+1)'(r_c);
        case (r_state)
            tds_pkg::S_DIVA: div_start = !zero_den;
            tds_pkg::S_DIVB: begin
                div_start = 1'b1;
                div_num   = (W+1)'(r_num);
            end
            default: div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ra <= r_alpha_mem[rd_addr];
        r_rb <= r_beta_mem[rd_addr];
        if (r_state == tds_pkg::S_WR) begin
            r_alpha_mem[idx] <= r_alpha;
            r_beta_mem[idx]  <= r_beta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tds_pkg::S_IDLE;
            r_count <= '0;
            r_err   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == tds_pkg::S_BOUT) begin
                r_ov <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                tds_pkg::S_RD: begin
                    if (r_count >= CW'(MAX_N)) r_err <= 1'b1;
                end
                tds_pkg::S_DIVA: if (zero_den) r_err <= 1'b1;
                tds_pkg::S_WR:   r_count <= r_count + 1'b1;
                tds_pkg::S_BOUT: begin
                    if (r_k == '0) begin
                        r_count <= '0;
                        r_err   <= 1'b0;
                    end
                end
                default: r_err <= r_err;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a    <= i_sub_coef;
            r_b    <= i_diag_coef;
            r_c    <= i_last_row ? '0 : i_super_coef;
            r_d    <= i_rhs_value;
            r_last <= i_last_row;
        end
        case (r_state)
            tds_pkg::S_MUL: begin
                r_p1 <= r_a * r_ra;
                r_p2 <= r_a * r_rb;
            end
            tds_pkg::S_SUM: begin
                if (r_count == '0) begin
                    r_den <= r_b;
                    r_num <= r_d;
                end else begin
                    r_den <= tds_pkg::sat(66'(r_b) + 66'(pm1));
                    r_num <= tds_pkg::sat(66'(r_d) - 66'(pm2));
                end
                r_alpha <= '0;
                r_beta  <= '0;
            end
            tds_pkg::S_WAITA: if (div_done) r_alpha <= div_quo;
            tds_pkg::S_WAITB: if (div_done) r_beta <= div_quo;
            tds_pkg::S_WR: begin
                r_k          <= idx;
                r_first_back <= 1'b1;
            end
            tds_pkg::S_RD: begin
                if (r_count >= CW'(MAX_N)) begin
                    r_k          <= AW'(MAX_N - 1);
                    r_first_back <= 1'b1;
                end
            end
            tds_pkg::S_BMUL: r_p1 <= r_ra * r_x;
            tds_pkg::S_BOUT: begin
                if (r_first_back) r_x <= r_rb;
                else r_x <= tds_pkg::sat(66'(pm1) + 66'(r_rb));
                r_ov_val <= r_err ? '0
                          : (r_first_back ? r_rb : tds_pkg::sat(66'(pm1) + 66'(r_rb)));
                r_ov_idx <= tds_pkg::IDX_W'(r_k);
                r_ov_fin <= (r_k == '0);
                r_ov_err <= r_err;
                r_first_back <= 1'b0;
                r_k <= r_k - 1'b1;
            end
            default: r_first_back <= r_first_back;
        endcase
    end

    assign o_valid          = r_ov;
    assign o_solution_value = r_ov_val;
    assign o_solution_index = r_ov_idx;
    assign o_final_entry    = r_ov_fin;
    assign o_solve_error    = r_ov_err;

    `TDS_ASSERT(a_idle_ready, i_clk, i_rst_n, (r_state == tds_pkg::S_IDLE) |-> !o_stall, "stall while idle")
    `TDS_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CW'(MAX_N), "row count overflow")
    `TDS_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_solution_value)), "output lost")
    `TDS_ASSERT(a_err_zero, i_clk, i_rst_n, (o_valid && o_solve_error) |-> (o_solution_value == '0), "error value")
endmodule

/* verif/tridiagonal_solver_checker.sv */
// ----------------------------------------------------------------------------
// tridiagonal_solver_checker
// Watches both channels of the tridiagonal solver. It keeps its own copy of
// the forward-sweep coefficients and predicts the back-substitution results
// of every system, then compares each result transfer against them.
// ----------------------------------------------------------------------------
module tridiagonal_solver_checker #(
    parameter int MAX_N     = tds_pkg::MAX_N_DEF,
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                i_stall_in,
    input  logic signed [tds_pkg::W-1:0]        i_sub_coef,
    input  logic signed [tds_pkg::W-1:0]        i_diag_coef,
    input  logic signed [tds_pkg::W-1:0]        i_super_coef,
    input  logic signed [tds_pkg::W-1:0]        i_rhs_value,
    input  logic                                i_last_row,
    input  logic                                i_out_valid,
    input  logic                                i_stall_out,
    input  logic signed [tds_pkg::W-1:0]        i_solution_value,
    input  logic [tds_pkg::IDX_W-1:0]           i_solution_index,
    input  logic                                i_final_entry,
    input  logic                                i_solve_error,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_result_count
);
    typedef logic signed [tds_pkg::W-1:0] t_q;

    typedef struct packed {
        t_q                         value;
        logic [tds_pkg::IDX_W-1:0]  index;
        logic                       final_entry;
        logic                       error;
    } t_solution;

    t_q        alpha_coef[MAX_N];
    t_q        beta_coef[MAX_N];
    int        rows_held;
    bit        system_error;
    t_solution solution_queue[$];

    function automatic t_q clamp(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -128'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic t_q fx_mul(input t_q a, input t_q b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clamp(p >>> FRAC_BITS);
    endfunction

    function automatic t_q fx_div(input logic signed [127:0] num, input t_q den);
        logic signed [127:0] scaled;
        scaled = num <<< FRAC_BITS;
        return clamp(scaled / 128'(den));
    endfunction

    task automatic sweep_row(input t_q a, input t_q b, input t_q c, input t_q d,
                             input bit last);
        t_q        den;
        t_q        bnum;
        t_q        x;
        t_solution s;
        if (last) c = '0;
        if (rows_held >= MAX_N) begin
            system_error = 1'b1;
        end else begin
            if (rows_held == 0) begin
                den  = b;
                bnum = d;
            end else begin
                den  = clamp(128'(b) + 128'(fx_mul(a, alpha_coef[rows_held-1])));
                bnum = clamp(128'(d) - 128'(fx_mul(a, beta_coef[rows_held-1])));
            end
            if (den == 0) begin
                system_error = 1'b1;
                alpha_coef[rows_held] = '0;
                beta_coef[rows_held]  = '0;
            end else begin
                alpha_coef[rows_held] = fx_div(-128'(c), den);
                beta_coef[rows_held]  = fx_div(128'(bnum), den);
            end
            rows_held++;
        end
        if (last) begin
            x = '0;
            for (int k = rows_held - 1; k >= 0; k--) begin
                if (k == rows_held - 1) x = beta_coef[k];
                else x = clamp(128'(fx_mul(alpha_coef[k], x)) + 128'(beta_coef[k]));
                s.value       = system_error ? '0 : x;
                s.index       = k[tds_pkg::IDX_W-1:0];
                s.final_entry = (k == 0);
                s.error       = system_error;
                solution_queue.push_back(s);
            end
            rows_held    = 0;
            system_error = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_solution exp_s;
        if (!i_rst_n) begin
            rows_held      = 0;
            system_error   = 1'b0;
            o_fail_count   = 0;
            o_result_count = 0;
            solution_queue.delete();
        end else begin
            if (i_out_valid && !i_stall_out) begin
                o_result_count++;
                if (solution_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual value=%0d index=%0d",
                             $time, i_solution_value, i_solution_index);
                    o_fail_count++;
                end else begin
                    exp_s = solution_queue.pop_front();
                    if (exp_s.value !== i_solution_value
                        || exp_s.index !== i_solution_index
                        || exp_s.final_entry !== i_final_entry
                        || exp_s.error !== i_solve_error) begin
                        $display("%0t: mismatch expected value=%0d index=%0d final=%0b err=%0b",
                                 $time, exp_s.value, exp_s.index, exp_s.final_entry,
                                 exp_s.error);
                        $display("%0t:          actual value=%0d index=%0d final=%0b err=%0b",
                                 $time, i_solution_value, i_solution_index,
                                 i_final_entry, i_solve_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !i_stall_in)
                sweep_row(i_sub_coef, i_diag_coef, i_super_coef, i_rhs_value, i_last_row);
        end
        o_pending = solution_queue.size();
    end
endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives rows of tridiagonal systems into the solver with random gaps and
// output stalls: directed edge, overlong and full-size systems first, then
// mostly small random systems, a few long ones. The checker predicts results.
// ----------------------------------------------------------------------------
module testbench;
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic signed [tds_pkg::W-1:0]      i_sub_coef = '0;
    logic signed [tds_pkg::W-1:0]      i_diag_coef = '0;
    logic signed [tds_pkg::W-1:0]      i_super_coef = '0;
    logic signed [tds_pkg::W-1:0]      i_rhs_value = '0;
    logic                              i_last_row = 1'b0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic signed [tds_pkg::W-1:0]      o_solution_value;
    logic [tds_pkg::IDX_W-1:0]         o_solution_index;
    logic                              o_final_entry;
    logic                              o_solve_error;
    int                                fail_count;
    int                                pending;
    int                                result_count;
    int                                send_idle_pct = 21;
    int                                recv_idle_pct = 64;
    int                                rows_sent = 0;
    int                                systems_sent = 0;

    always #5 i_clk = ~i_clk;

    tridiagonal_solver dut (.*);

    tridiagonal_solver_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_sub_coef, .i_diag_coef, .i_super_coef, .i_rhs_value, .i_last_row,
        .i_out_valid(o_valid), .i_stall_out(i_stall),
        .i_solution_value(o_solution_value), .i_solution_index(o_solution_index),
        .i_final_entry(o_final_entry), .i_solve_error(o_solve_error),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    task automatic send_row(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_sub_coef   <= a;
        i_diag_coef  <= b;
        i_super_coef <= c;
        i_rhs_value  <= d;
        i_last_row   <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        rows_sent++;
    endtask

    task automatic send_system(input int rows, input bit wild);
        logic [31:0] b;
        for (int r = 0; r < rows; r++) begin
            b = wild ? pick_coef() : 32'($signed($urandom_range(6 << 16)) + (4 << 16));
            if (!wild && $urandom_range(1)) b = -b;
            send_row(wild ? pick_coef() : $urandom_range(65535),
                     b,
                     wild ? pick_coef() : $urandom_range(65535),
                     wild ? pick_coef() : $urandom,
                     r == rows - 1);
        end
        systems_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_row(32'h7FFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'h0005_0000, 1'b1);
        send_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_row(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_row(32'h0001_0000, 32'h0002_0000, 32'h0, 32'hFFFF_FFFF, 1'b1);
        send_row(32'h0, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_row(32'h0000_0001, 32'h0002_0000, 32'h1234_5678, 32'h8000_0000, 1'b0);
        send_row(32'hFFFF_0000, 32'h0003_0000, 32'hAAAA_5555, 32'h5555_AAAA, 1'b1);
        drain();
        send_system(tds_pkg::MAX_N_DEF + 2, 1'b0);
        drain();
        send_system(tds_pkg::MAX_N_DEF, 1'b0);
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 21 : 0;
            while (rows_sent < 150 * (ph + 1) + 20) begin
                send_system(($urandom_range(19) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6),
                            $urandom_range(3) == 0);
                if ($urandom_range(9) == 0) drain();
            end
        end
        drain();
        repeat (200) @(negedge i_clk);
        $display("Sent %0d rows in %0d systems; checked %0d solution entries.",
                 rows_sent, systems_sent, result_count);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout after %0d rows.", rows_sent);
        $display("Regression FAIL");
        $finish;
    end
endmodule
